// ----- rtl/s2c_pkg.sv -----
// Shared types, constants and the arctangent table of the spherical-to-Cartesian unit.
`timescale 1ns / 1ps

package s2c_pkg;

    // Q30 CORDIC word and Q16 trig value
    typedef logic signed [31:0] t_q30;
    typedef logic signed [17:0] t_trig;
    typedef logic [1:0]         t_quad;

    // Fields that travel beside the angle datapath
    typedef struct packed {
        logic [15:0] range_mm;
        logic [7:0]  intensity;
        logic        last;
    } t_side;

    // Quadrant codes
    localparam t_quad QUAD_0 = 2'd0;
    localparam t_quad QUAD_1 = 2'd1;
    localparam t_quad QUAD_2 = 2'd2;
    localparam t_quad QUAD_3 = 2'd3;

    // Angle units: hundredths of a degree
    localparam int unsigned FULL_CDEG = 36000;
    localparam int unsigned QUAD_CDEG = 9000;

    // Radian conversion: z = (m * PI_Q30 + ZDIV / 2) / ZDIV, with PI_Q30 split
    // into a whole multiple of ZDIV and a remainder
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam int unsigned     ZDIV        = 18000;
    localparam int unsigned     PI_INT      = int'(PI_Q30 / ZDIV);
    localparam int unsigned     PI_FRAC     = int'(PI_Q30 % ZDIV);
    localparam int unsigned     RECIP_SHIFT = 40;
    localparam logic [25:0]     ZDIV_RECIP  = 26'((64'd1 << RECIP_SHIFT) / ZDIV);

    // CORDIC
    localparam int unsigned ATAN_ENTRIES = 24;
    localparam t_q30 GAIN_Q30  = 32'sd652032874;
    localparam t_q30 ROUND_Q16 = 32'sd8192;

    localparam t_q30 ATAN_Q30 [ATAN_ENTRIES] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128
    };

    // Pipeline depths of the angle front end and the coordinate back end
    localparam int unsigned PREP_LAT  = 6;
    localparam int unsigned COORD_LAT = 6;

endpackage

// ----- rtl/s2c_angle_prep.sv -----
// Angle front end: wrap to one turn, split off the quadrant, convert to Q30 radians.
`timescale 1ns / 1ps

module s2c_angle_prep import s2c_pkg::*; (
    input  logic               i_clk,
    input  logic signed [16:0] i_ang,
    output t_q30               o_z,
    output t_quad              o_q
);

    localparam logic signed [16:0] FULL_S = 17'(FULL_CDEG);
    localparam logic [15:0] Q1_CDEG = 16'(QUAD_CDEG);
    localparam logic [15:0] Q2_CDEG = 16'(2 * QUAD_CDEG);
    localparam logic [15:0] Q3_CDEG = 16'(3 * QUAD_CDEG);

    logic signed [16:0] n_wrap;
    logic [15:0]        r_a;
    t_quad              n_q;
    logic [15:0]        n_base;
    t_quad              r_q2, r_q3, r_q4, r_q5, r_q6;
    logic [13:0]        r_m;
    logic [31:0]        r_hi3, r_hi4, r_hi5;
    logic [25:0]        r_v3, r_v4, r_v5;
    logic [51:0]        n_prod;
    logic [11:0]        r_test;
    logic [25:0]        n_rem;
    logic [11:0]        n_t;
    t_q30               r_z;

    // Wrap into one turn
    always_comb begin
        if (i_ang < 17'sd0) begin
            n_wrap = i_ang + FULL_S;
        end else if (i_ang >= FULL_S) begin
            n_wrap = i_ang - FULL_S;
        end else begin
            n_wrap = i_ang;
        end
    end

    // Pick the quadrant
    always_comb begin
        if (r_a >= Q3_CDEG) begin
            n_q    = QUAD_3;
            n_base = Q3_CDEG;
        end else if (r_a >= Q2_CDEG) begin
            n_q    = QUAD_2;
            n_base = Q2_CDEG;
        end else if (r_a >= Q1_CDEG) begin
            n_q    = QUAD_1;
            n_base = Q1_CDEG;
        end else begin
            n_q    = QUAD_0;
            n_base = 16'd0;
        end
    end

    // Estimate remainder-part quotient by reciprocal, then correct once
    assign n_prod = 52'(r_v4) * 52'(ZDIV_RECIP);
    assign n_rem  = r_v5 - 26'(r_test) * 26'(ZDIV);
    assign n_t    = (n_rem >= 26'(ZDIV)) ? r_test + 12'd1 : r_test;

    always_ff @(posedge i_clk) begin
        r_a    <= n_wrap[15:0];
        r_q2   <= n_q;
        r_m    <= 14'(r_a - n_base);
        r_q3   <= r_q2;
        r_hi3  <= 32'(r_m) * 32'(PI_INT);
        r_v3   <= 26'(r_m) * 26'(PI_FRAC) + 26'(ZDIV / 2);
        r_q4   <= r_q3;
        r_hi4  <= r_hi3;
        r_v4   <= r_v3;
        r_test <= n_prod[51:40];
        r_q5   <= r_q4;
        r_hi5  <= r_hi4;
        r_v5   <= r_v4;
        r_q6   <= r_q5;
        r_z    <= t_q30'(r_hi5 + 32'(n_t));
    end

    assign o_z = r_z;
    assign o_q = r_q6;

endmodule

// ----- rtl/s2c_cordic_cell.sv -----
// One rotation-mode CORDIC iteration with its output register.
`timescale 1ns / 1ps

module s2c_cordic_cell import s2c_pkg::*; #(
    parameter int unsigned STAGE = 0
) (
    input  logic  i_clk,
    input  t_q30  i_x,
    input  t_q30  i_y,
    input  t_q30  i_z,
    input  t_quad i_q,
    output t_q30  o_x,
    output t_q30  o_y,
    output t_q30  o_z,
    output t_quad o_q
);

    localparam t_q30 ATAN = ATAN_Q30[STAGE];

    t_q30  n_dx, n_dy;
    t_q30  r_x, r_y, r_z;
    t_quad r_q;

    assign n_dx = i_y >>> STAGE;
    assign n_dy = i_x >>> STAGE;

    // Rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (!i_z[31]) begin
            r_x <= i_x - n_dx;
            r_y <= i_y + n_dy;
            r_z <= i_z - ATAN;
        end else begin
            r_x <= i_x + n_dx;
            r_y <= i_y - n_dy;
            r_z <= i_z + ATAN;
        end
        r_q <= i_q;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_q = r_q;

endmodule

// ----- rtl/s2c_coord.sv -----
// Back end: round CORDIC results to Q16, unfold quadrants, scale by range, saturate.
`timescale 1ns / 1ps

module s2c_coord import s2c_pkg::*; (
    input  logic               i_clk,
    input  t_q30               i_az_x,
    input  t_q30               i_az_y,
    input  t_quad              i_az_q,
    input  t_q30               i_el_x,
    input  t_q30               i_el_y,
    input  t_quad              i_el_q,
    input  t_side              i_side,
    output logic signed [16:0] o_x_mm,
    output logic signed [16:0] o_y_mm,
    output logic signed [16:0] o_z_mm,
    output logic [7:0]         o_intensity_out,
    output logic               o_no_return,
    output logic               o_last_in_cloud
);

    localparam int unsigned SD_LEN = COORD_LAT - 1;
    localparam logic signed [20:0] RAW_MAX = 21'sd65535;
    localparam logic signed [52:0] XY_HALF = 53'sd2147483648;
    localparam logic signed [34:0] Z_HALF  = 35'sd32768;

    t_q30               n_azc, n_azs, n_elc, n_els;
    t_trig              r_azc, r_azs, r_elc, r_els;
    t_quad              r_az_q, r_el_q;
    t_trig              r_sa, r_ca, r_se, r_ce;
    t_side              r_sd [SD_LEN];
    logic signed [16:0] n_r;
    logic signed [34:0] r_rce, r_rse, r_rse2;
    t_trig              r_sa3, r_ca3;
    logic signed [52:0] r_px, r_py;
    logic signed [52:0] n_xs, n_ys;
    logic signed [34:0] n_zs;
    logic signed [20:0] r_xr, r_yr, r_zr;

    function automatic logic signed [16:0] sat_coord(input logic signed [20:0] v);
        logic signed [16:0] s;
        if (v > RAW_MAX) begin
            s = 17'sd65535;
        end else if (v < -RAW_MAX) begin
            s = -17'sd65535;
        end else begin
            s = v[16:0];
        end
        return s;
    endfunction

    // Round Q30 to Q16 (floor after adding half)
    assign n_azc = i_az_x + ROUND_Q16;
    assign n_azs = i_az_y + ROUND_Q16;
    assign n_elc = i_el_x + ROUND_Q16;
    assign n_els = i_el_y + ROUND_Q16;

    assign n_r  = signed'({1'b0, r_sd[1].range_mm});
    assign n_xs = r_px + XY_HALF;
    assign n_ys = r_py + XY_HALF;
    assign n_zs = r_rse2 + Z_HALF;

    // Carry the sideband fields along
    always_ff @(posedge i_clk) begin
        r_sd[0] <= i_side;
        for (int k = 1; k < SD_LEN; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // Round stage
    always_ff @(posedge i_clk) begin
        r_azc <= t_trig'(n_azc[31:14]);
        r_azs <= t_trig'(n_azs[31:14]);
        r_elc <= t_trig'(n_elc[31:14]);
        r_els <= t_trig'(n_els[31:14]);
    end

    // Hold quadrant codes beside the round stage
    always_ff @(posedge i_clk) begin
        r_az_q <= i_az_q;
        r_el_q <= i_el_q;
    end

    // Unfold quadrants
    always_ff @(posedge i_clk) begin
        case (r_az_q)
            QUAD_0: begin
                r_ca <= r_azc;
                r_sa <= r_azs;
            end
            QUAD_1: begin
                r_ca <= -r_azs;
                r_sa <= r_azc;
            end
            QUAD_2: begin
                r_ca <= -r_azc;
                r_sa <= -r_azs;
            end
            default: begin
                r_ca <= r_azs;
                r_sa <= -r_azc;
            end
        endcase
        case (r_el_q)
            QUAD_0: begin
                r_ce <= r_elc;
                r_se <= r_els;
            end
            QUAD_1: begin
                r_ce <= -r_els;
                r_se <= r_elc;
            end
            QUAD_2: begin
                r_ce <= -r_elc;
                r_se <= -r_els;
            end
            default: begin
                r_ce <= r_els;
                r_se <= -r_elc;
            end
        endcase
    end

    // Scale by range, then by the azimuth terms
    always_ff @(posedge i_clk) begin
        r_rce  <= 35'(n_r) * 35'(r_ce);
        r_rse  <= 35'(n_r) * 35'(r_se);
        r_sa3  <= r_sa;
        r_ca3  <= r_ca;
        r_px   <= 53'(r_rce) * 53'(r_sa3);
        r_py   <= 53'(r_rce) * 53'(r_ca3);
        r_rse2 <= r_rse;
        r_xr   <= n_xs[52:32];
        r_yr   <= n_ys[52:32];
        r_zr   <= 21'(signed'(n_zs[34:16]));
    end

    // Saturate and flag empty points
    always_ff @(posedge i_clk) begin
        o_x_mm          <= sat_coord(r_xr);
        o_y_mm          <= sat_coord(r_yr);
        o_z_mm          <= sat_coord(r_zr);
        o_no_return     <= (r_xr == 21'sd0) && (r_yr == 21'sd0) && (r_zr == 21'sd0);
        o_intensity_out <= r_sd[SD_LEN-1].intensity;
        o_last_in_cloud <= r_sd[SD_LEN-1].last;
    end

endmodule

// ----- rtl/lidar_spherical_to_cartesian_unit.sv -----
// Top level: lidar return (range, azimuth, elevation) to Cartesian point.
`timescale 1ns / 1ps

// Converts one lidar return per clock into x, y, z in whole millimetres with a
// fully pipelined datapath: a transaction is taken at every edge where start is
// high, and busy stays low. Each result appears on the o_ ports for one cycle
// with o_valid high once its transaction has passed the whole pipeline (CORDIC
// stage count capped at 24); results come out in order, one per input.
// Depth is set by the two rows of CORDIC cells, one iteration per cell, plus the
// registered angle preparation and the rounding, scaling and saturation stages.
// The output cannot be stalled; a receiver must take each result as it appears.
// Coordinates saturate at +/-65535 mm, and o_no_return is set when all three are zero.
module lidar_spherical_to_cartesian_unit import s2c_pkg::*; #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_range_mm,
    input  logic [15:0]        i_azimuth_cdeg,
    input  logic signed [14:0] i_elevation_cdeg,
    input  logic [7:0]         i_intensity_in,
    input  logic               i_last_in_scan,
    output logic               o_valid,
    output logic signed [16:0] o_x_mm,
    output logic signed [16:0] o_y_mm,
    output logic signed [16:0] o_z_mm,
    output logic [7:0]         o_intensity_out,
    output logic               o_no_return,
    output logic               o_last_in_cloud
);

    localparam int unsigned N_EFF  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                   : CORDIC_STAGES;
    localparam int unsigned SB_LEN = PREP_LAT + N_EFF;
    localparam int unsigned LAT    = SB_LEN + COORD_LAT;

    logic             n_accept;
    logic [LAT-1:0]   r_vld;
    t_side            r_side [SB_LEN];
    t_q30             w_az_x [N_EFF+1];
    t_q30             w_az_y [N_EFF+1];
    t_q30             w_az_z [N_EFF+1];
    t_quad            w_az_q [N_EFF+1];
    t_q30             w_el_x [N_EFF+1];
    t_q30             w_el_y [N_EFF+1];
    t_q30             w_el_z [N_EFF+1];
    t_quad            w_el_q [N_EFF+1];

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    // Advance the valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], n_accept};
        end
    end

    assign o_valid = r_vld[LAT-1];

    // Delay range, intensity and end mark alongside the angle datapath
    always_ff @(posedge i_clk) begin
        r_side[0] <= '{range_mm: i_range_mm, intensity: i_intensity_in,
                       last: i_last_in_scan};
        for (int k = 1; k < SB_LEN; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // Angle front ends
    s2c_angle_prep u_prep_az (
        .i_clk (i_clk),
        .i_ang (signed'({1'b0, i_azimuth_cdeg})),
        .o_z   (w_az_z[0]),
        .o_q   (w_az_q[0])
    );

    s2c_angle_prep u_prep_el (
        .i_clk (i_clk),
        .i_ang (17'(i_elevation_cdeg)),
        .o_z   (w_el_z[0]),
        .o_q   (w_el_q[0])
    );

    assign w_az_x[0] = GAIN_Q30;
    assign w_az_y[0] = '0;
    assign w_el_x[0] = GAIN_Q30;
    assign w_el_y[0] = '0;

    // Two rows of CORDIC cells
    for (genvar g = 0; g < N_EFF; g++) begin : g_cordic
        s2c_cordic_cell #(.STAGE(g)) u_cell_az (
            .i_clk (i_clk),
            .i_x   (w_az_x[g]),
            .i_y   (w_az_y[g]),
            .i_z   (w_az_z[g]),
            .i_q   (w_az_q[g]),
            .o_x   (w_az_x[g+1]),
            .o_y   (w_az_y[g+1]),
            .o_z   (w_az_z[g+1]),
            .o_q   (w_az_q[g+1])
        );
        s2c_cordic_cell #(.STAGE(g)) u_cell_el (
            .i_clk (i_clk),
            .i_x   (w_el_x[g]),
            .i_y   (w_el_y[g]),
            .i_z   (w_el_z[g]),
            .i_q   (w_el_q[g]),
            .o_x   (w_el_x[g+1]),
            .o_y   (w_el_y[g+1]),
            .o_z   (w_el_z[g+1]),
            .o_q   (w_el_q[g+1])
        );
    end

    // Coordinate back end
    s2c_coord u_coord (
        .i_clk           (i_clk),
        .i_az_x          (w_az_x[N_EFF]),
        .i_az_y          (w_az_y[N_EFF]),
        .i_az_q          (w_az_q[N_EFF]),
        .i_el_x          (w_el_x[N_EFF]),
        .i_el_y          (w_el_y[N_EFF]),
        .i_el_q          (w_el_q[N_EFF]),
        .i_side          (r_side[SB_LEN-1]),
        .o_x_mm          (o_x_mm),
        .o_y_mm          (o_y_mm),
        .o_z_mm          (o_z_mm),
        .o_intensity_out (o_intensity_out),
        .o_no_return     (o_no_return),
        .o_last_in_cloud (o_last_in_cloud)
    );

    // Every taken transaction yields a result after the fixed depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##LAT o_valid)
        else $error("result missing after pipeline depth");

    // Sideband fields stay aligned with their transaction
    a_side_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_intensity_out == $past(i_intensity_in, LAT))
                 && (o_last_in_cloud == $past(i_last_in_scan, LAT)))
        else $error("intensity or end mark out of step with coordinates");

    // A zero range gives an empty point
    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_range_mm == 16'd0, LAT)) |-> o_no_return)
        else $error("zero range not flagged as no return");

endmodule

// ----- test/tb_lidar_spherical_to_cartesian_unit.sv -----
// Self-checking testbench of the lidar spherical-to-Cartesian unit.
`timescale 1ns / 1ps

module tb_lidar_spherical_to_cartesian_unit;
    import s2c_pkg::*;

    localparam int unsigned STAGES        = 16;
    localparam int unsigned TRIG_TAB_LEN  = 24;
    localparam int unsigned LATENCY       = ((STAGES > TRIG_TAB_LEN) ? TRIG_TAB_LEN : STAGES) + 12;
    localparam int unsigned RANDOM_POINTS = 600;
    localparam int unsigned IDLE_LIMIT    = 2000;

    localparam longint GAIN_Q30_TB  = 64'sd652032874;
    localparam longint RAD_PER_HALF = 64'sd3373259426;
    localparam longint COORD_LIMIT  = 64'sd65535;

    typedef struct {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic [7:0]         intensity;
        logic               no_return;
        logic               last;
    } cartesian_point_t;

    // Predict each converted point and match results in arrival order
    class point_scoreboard;
        cartesian_point_t expected_points[$];
        int unsigned      mismatches;
        int unsigned      points_sent;
        int unsigned      points_checked;
        int unsigned      empty_points;
        int unsigned      limit_points;

        function new();
            mismatches     = 0;
            points_sent    = 0;
            points_checked = 0;
            empty_points   = 0;
            limit_points   = 0;
        endfunction

        // Arctangent of 2^-i in Q30; from stage 10 on it equals 2^-i itself
        function longint atan_step(int i);
            case (i)
                0:       return 64'sd843314857;
                1:       return 64'sd497837829;
                2:       return 64'sd263043837;
                3:       return 64'sd133525159;
                4:       return 64'sd67021687;
                5:       return 64'sd33543516;
                6:       return 64'sd16775851;
                7:       return 64'sd8388437;
                8:       return 64'sd4194283;
                9:       return 64'sd2097149;
                default: return 64'sd1 <<< (30 - i);
            endcase
        endfunction

        // Rotate the gain vector through the in-quadrant angle, then fold the quadrant back in
        function void sin_cos_q16(longint ang, output longint s, output longint c);
            longint q;
            longint m;
            longint rad;
            longint xr;
            longint yr;
            longint dx;
            longint dy;
            longint cq;
            longint sq;
            q   = ang / 9000;
            m   = ang - q * 9000;
            rad = (m * RAD_PER_HALF + 9000) / 18000;
            xr  = GAIN_Q30_TB;
            yr  = 0;
            for (int i = 0; i < STAGES && i < TRIG_TAB_LEN; i++) begin
                dx = yr >>> i;
                dy = xr >>> i;
                if (rad >= 0) begin
                    xr  = xr - dx;
                    yr  = yr + dy;
                    rad = rad - atan_step(i);
                end else begin
                    xr  = xr + dx;
                    yr  = yr - dy;
                    rad = rad + atan_step(i);
                end
            end
            cq = (xr + 64'sd8192) >>> 14;
            sq = (yr + 64'sd8192) >>> 14;
            case (t_quad'(q))
                QUAD_0: begin
                    c = cq;
                    s = sq;
                end
                QUAD_1: begin
                    c = -sq;
                    s = cq;
                end
                QUAD_2: begin
                    c = -cq;
                    s = -sq;
                end
                default: begin
                    c = sq;
                    s = -cq;
                end
            endcase
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_LIMIT)
                return COORD_LIMIT;
            if (v < -COORD_LIMIT)
                return -COORD_LIMIT;
            return v;
        endfunction

        // Convert one return to its expected point
        function cartesian_point_t project_return(logic [15:0] r, logic [15:0] az,
                                                  logic signed [14:0] el, logic [7:0] inten,
                                                  logic last);
            cartesian_point_t p;
            longint rng;
            longint azv;
            longint elv;
            longint sa;
            longint ca;
            longint se;
            longint ce;
            longint xv;
            longint yv;
            longint zv;
            rng = longint'(r);
            azv = longint'(az);
            elv = longint'(el);
            if (elv < 0)
                elv = elv + 36000;
            if (azv >= 36000)
                azv = azv - 36000;
            sin_cos_q16(azv, sa, ca);
            sin_cos_q16(elv, se, ce);
            xv = clamp_coord((rng * ce * sa + 64'sd2147483648) >>> 32);
            yv = clamp_coord((rng * ce * ca + 64'sd2147483648) >>> 32);
            zv = clamp_coord((rng * se + 64'sd32768) >>> 16);
            p.x         = 17'(xv);
            p.y         = 17'(yv);
            p.z         = 17'(zv);
            p.intensity = inten;
            p.no_return = (xv == 0 && yv == 0 && zv == 0);
            p.last      = last;
            return p;
        endfunction

        function void note_input(logic [15:0] r, logic [15:0] az, logic signed [14:0] el,
                                 logic [7:0] inten, logic last);
            cartesian_point_t p;
            p = project_return(r, az, el, inten, last);
            points_sent++;
            if (p.no_return)
                empty_points++;
            if (p.x == 17'sd65535 || p.x == -17'sd65535 || p.y == 17'sd65535 ||
                p.y == -17'sd65535 || p.z == 17'sd65535 || p.z == -17'sd65535)
                limit_points++;
            expected_points.insert(expected_points.size(), p);
        endfunction

        function void compare_field(string name, logic signed [17:0] e, logic signed [17:0] a);
            if (a !== e) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(cartesian_point_t got);
            cartesian_point_t exp_pt;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual x=%0d y=%0d z=%0d",
                         $time, got.x, got.y, got.z);
                mismatches++;
                return;
            end
            exp_pt = expected_points.pop_front();
            points_checked++;
            compare_field("x_mm", exp_pt.x, got.x);
            compare_field("y_mm", exp_pt.y, got.y);
            compare_field("z_mm", exp_pt.z, got.z);
            compare_field("intensity_out", exp_pt.intensity, got.intensity);
            compare_field("no_return", exp_pt.no_return, got.no_return);
            compare_field("last_in_cloud", exp_pt.last, got.last);
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [15:0]        i_range_mm       = '0;
    logic [15:0]        i_azimuth_cdeg   = '0;
    logic signed [14:0] i_elevation_cdeg = '0;
    logic [7:0]         i_intensity_in   = '0;
    logic               i_last_in_scan   = 1'b0;
    logic               o_valid;
    logic signed [16:0] o_x_mm;
    logic signed [16:0] o_y_mm;
    logic signed [16:0] o_z_mm;
    logic [7:0]         o_intensity_out;
    logic               o_no_return;
    logic               o_last_in_cloud;

    int unsigned     idle_cycles = 0;
    point_scoreboard sb = new();

    lidar_spherical_to_cartesian_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_range_mm      (i_range_mm),
        .i_azimuth_cdeg  (i_azimuth_cdeg),
        .i_elevation_cdeg(i_elevation_cdeg),
        .i_intensity_in  (i_intensity_in),
        .i_last_in_scan  (i_last_in_scan),
        .o_valid         (o_valid),
        .o_x_mm          (o_x_mm),
        .o_y_mm          (o_y_mm),
        .o_z_mm          (o_z_mm),
        .o_intensity_out (o_intensity_out),
        .o_no_return     (o_no_return),
        .o_last_in_cloud (o_last_in_cloud)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Capture every strobed result and check it
    always @(posedge i_clk) begin : result_monitor
        cartesian_point_t seen;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            seen.x         = o_x_mm;
            seen.y         = o_y_mm;
            seen.z         = o_z_mm;
            seen.intensity = o_intensity_out;
            seen.no_return = o_no_return;
            seen.last      = o_last_in_cloud;
            sb.check_result(seen);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
            $display("lidar_spherical_to_cartesian_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Idle with start low when gap is nonzero, then present one return and hold it until taken
    task automatic send_point(input logic [15:0] r, input logic [15:0] az,
                              input logic signed [14:0] el, input logic [7:0] inten,
                              input logic last, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_range_mm       <= r;
        i_azimuth_cdeg   <= az;
        i_elevation_cdeg <= el;
        i_intensity_in   <= inten;
        i_last_in_scan   <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_input(r, az, el, inten, last);
    endtask

    // Hold off until every outstanding point has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        bit                 steady;
        int unsigned        sel;
        int unsigned        k;
        logic [15:0]        r;
        logic [15:0]        az;
        logic signed [14:0] el;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero range, cardinal angles, poles, wraps, saturation, tiny ranges
        send_point(16'd0,     16'd0,     15'sd0,      8'd0,   1'b0, 0);
        send_point(16'd65535, 16'd0,     15'sd0,      8'd255, 1'b0, 0);
        send_point(16'd65535, 16'd9000,  15'sd0,      8'd1,   1'b0, 0);
        send_point(16'd65535, 16'd18000, 15'sd0,      8'd128, 1'b0, 1);
        send_point(16'd65535, 16'd27000, 15'sd0,      8'd127, 1'b0, 0);
        send_point(16'd65535, 16'd35999, 15'sd0,      8'd0,   1'b1, 0);
        send_point(16'd65535, 16'd0,     15'sd9000,   8'd255, 1'b0, 0);
        send_point(16'd65535, 16'd0,     -15'sd9000,  8'd17,  1'b0, 2);
        send_point(16'd65535, 16'd36000, 15'sd0,      8'd34,  1'b0, 0);
        send_point(16'd65535, 16'd65535, 15'sd1,      8'd68,  1'b0, 0);
        send_point(16'd65535, 16'd4500,  15'sd16383,  8'd136, 1'b0, 0);
        send_point(16'd65535, 16'd4500,  -15'sd16384, 8'd85,  1'b1, 0);
        send_point(16'd1,     16'd4500,  15'sd4500,   8'd170, 1'b0, 0);
        send_point(16'd2,     16'd31500, -15'sd4500,  8'd51,  1'b0, 0);
        send_point(16'd0,     16'd12345, -15'sd8999,  8'd204, 1'b1, 0);
        send_point(16'd40000, 16'd12345, -15'sd4567,  8'd99,  1'b0, 0);
        send_point(16'd32768, 16'd8999,  15'sd8999,   8'd250, 1'b0, 3);
        send_point(16'd65535, 16'd9001,  -15'sd1,     8'd5,   1'b0, 0);
        drain();

        // Random returns: mostly in range, with boundary angles, wraps and extreme ranges
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            steady = ((n / 75) % 3) == 1;
            if (n == RANDOM_POINTS / 2)
                drain();

            sel = $urandom_range(0, 9);
            if (sel == 0)
                r = 16'($urandom_range(0, 3));
            else if (sel == 1)
                r = 16'(65535 - $urandom_range(0, 3));
            else
                r = 16'($urandom_range(0, 65535));

            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                az = 16'($urandom_range(36000, 65535));
            end else if (sel == 1) begin
                k  = $urandom_range(1, 4);
                az = 16'(k * 9000 - 1 + $urandom_range(0, 2));
            end else begin
                az = 16'($urandom_range(0, 35999));
            end

            sel = $urandom_range(0, 9);
            if (sel == 0)
                el = 15'($urandom_range(0, 32767));
            else if (sel == 1)
                el = 15'(($urandom_range(0, 1) ? 9000 : -9000) + int'($urandom_range(0, 2)) - 1);
            else
                el = 15'(int'($urandom_range(0, 18000)) - 9000);

            send_point(r, az, el, 8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                       pick_gap(steady));
        end

        // Let the pipeline empty, then watch for stray results
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Summary: %0d returns converted, %0d points checked, %0d mismatches",
                 sb.points_sent, sb.points_checked, sb.mismatches);
        $display("Covered: %0d no-return points, %0d points at the coordinate limit, %s",
                 sb.empty_points, sb.limit_points, "wrapped azimuths, elevations past the poles");
        if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
            $display("lidar_spherical_to_cartesian_unit verification clean");
        end else begin
            $display("lidar_spherical_to_cartesian_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/s2c_pkg.sv
rtl/s2c_angle_prep.sv
rtl/s2c_cordic_cell.sv
rtl/s2c_coord.sv
rtl/lidar_spherical_to_cartesian_unit.sv
test/tb_lidar_spherical_to_cartesian_unit.sv
